>>> rtl/assert_macros.svh
// Assertion helpers shared by the cache modules.
// Both expect clk and rst_n in scope; checks are off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or plain property.
`define SALC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property that holds in the cycle after the trigger.
`define SALC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/salc_pkg.sv
package salc_pkg;

  // Configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_SET_BITS    = 2'd0;
  localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS        = 2'd2;

  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int SET_BITS_W    = 3;
  localparam int OFFSET_BITS_W = 6;
  localparam int WAYS_CFG_W    = 4;
  localparam int TOTAL_W       = 32;

  localparam logic [1:0] OP_MODIFY = 2'd2;

  typedef struct packed {
    logic [SET_BITS_W-1:0]    set_bits;
    logic [OFFSET_BITS_W-1:0] offset_bits;
    logic [WAYS_CFG_W-1:0]    ways;
  } cfg_t;

  typedef struct packed {
    logic clear;
    logic load_in;
    logic decode;
    logic fetch;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_last;
    logic out_free;
  } dp_sts_t;

endpackage

>>> rtl/salc_regs.sv
module salc_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [salc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [salc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [salc_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output salc_pkg::cfg_t                     cfg
);

  logic [salc_pkg::SET_BITS_W-1:0]    set_bits_r;
  logic [salc_pkg::OFFSET_BITS_W-1:0] offset_bits_r;
  logic [salc_pkg::WAYS_CFG_W-1:0]    ways_r;
  logic [1:0]                         reg_idx;
  logic                               wr_en;

  assign reg_idx = paddr[salc_pkg::CFG_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r    <= '0;
      offset_bits_r <= '0;
      ways_r        <= salc_pkg::WAYS_CFG_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        salc_pkg::REG_SET_BITS: begin
          set_bits_r <= pwdata[salc_pkg::SET_BITS_W-1:0];
        end
        salc_pkg::REG_OFFSET_BITS: begin
          offset_bits_r <= pwdata[salc_pkg::OFFSET_BITS_W-1:0];
        end
        salc_pkg::REG_WAYS: begin
          ways_r <= pwdata[salc_pkg::WAYS_CFG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      salc_pkg::REG_SET_BITS:    prdata = salc_pkg::CFG_DATA_W'(set_bits_r);
      salc_pkg::REG_OFFSET_BITS: prdata = salc_pkg::CFG_DATA_W'(offset_bits_r);
      salc_pkg::REG_WAYS:        prdata = salc_pkg::CFG_DATA_W'(ways_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.set_bits    = set_bits_r;
  assign cfg.offset_bits = offset_bits_r;
  assign cfg.ways        = ways_r;

endmodule

>>> rtl/salc_ctrl.sv
`include "assert_macros.svh"

module salc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  salc_pkg::dp_sts_t sts,
  output salc_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_FETCH  = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_UPDATE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = ST_FETCH;
      ST_FETCH:  state_nxt = ST_SCAN;
      ST_SCAN:   if (sts.scan_last) state_nxt = ST_UPDATE;
      ST_UPDATE: if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.clear   = (state_r == ST_CLEAR);
  assign cmd.load_in = (state_r == ST_IDLE) & in_valid;
  assign cmd.decode  = (state_r == ST_DECODE);
  assign cmd.fetch   = (state_r == ST_FETCH);
  assign cmd.scan    = (state_r == ST_SCAN);
  assign cmd.commit  = (state_r == ST_UPDATE) & sts.out_free;

  `SALC_ASSERT_NEXT(a_scan_continues, state_r == ST_SCAN && !sts.scan_last,
    state_r == ST_SCAN, "way scan left early")
  `SALC_ASSERT_NEXT(a_commit_to_idle, cmd.commit, state_r == ST_IDLE && in_ready,
    "controller not idle after commit")

endmodule

>>> rtl/salc_dp.sv
`include "assert_macros.svh"

module salc_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  salc_pkg::cfg_t                   cfg,
  input  salc_pkg::dp_cmd_t                cmd,
  output salc_pkg::dp_sts_t                sts,
  input  logic [1:0]                       in_operation,
  input  logic [ADDR_WIDTH-1:0]            in_address,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_was_hit,
  output logic                             out_was_miss,
  output logic                             out_was_eviction,
  output logic                             out_modify_hit,
  output logic [salc_pkg::TOTAL_W-1:0]     out_hit_total,
  output logic [salc_pkg::TOTAL_W-1:0]     out_miss_total,
  output logic [salc_pkg::TOTAL_W-1:0]     out_eviction_total
);

  localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int NUM_SETS = 1 << SET_W;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int CNT_W    = $clog2(MAX_WAYS + 1);
  localparam int WX_W     = (CNT_W > salc_pkg::WAYS_CFG_W) ? CNT_W : salc_pkg::WAYS_CFG_W;
  localparam int SHAMT_W  = $clog2((1 << salc_pkg::OFFSET_BITS_W) + MAX_SET_BITS);
  localparam int TAG_DEPTH = NUM_SETS << WAY_W;
  localparam int TW       = salc_pkg::TOTAL_W;

  // Memories: per-set valid/rank rows and per-line tags
  logic [MAX_WAYS-1:0]             valid_mem [NUM_SETS];
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_mem  [NUM_SETS];
  logic [ADDR_WIDTH-1:0]           tag_mem   [TAG_DEPTH];

  logic [1:0]                      op_r;
  logic [ADDR_WIDTH-1:0]           addr_r;
  logic [SET_W-1:0]                set_r;
  logic [ADDR_WIDTH-1:0]           tag_r;
  logic [SET_W-1:0]                clr_cnt_r;

  logic [MAX_WAYS-1:0]             valid_rd_r;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_rd_r;
  logic [ADDR_WIDTH-1:0]           tag_rd_r;

  logic [WAY_W-1:0]                scan_way_r;
  logic                            hit_r;
  logic [WAY_W-1:0]                hit_way_r;
  logic [CNT_W-1:0]                nvalid_r;
  logic                            free_found_r;
  logic [WAY_W-1:0]                free_way_r;
  logic [WAY_W-1:0]                best_way_r;
  logic [RANK_W-1:0]               best_rank_r;

  logic [TW-1:0]                   hits_r;
  logic [TW-1:0]                   misses_r;
  logic [TW-1:0]                   evicts_r;

  logic                            out_valid_r;
  logic                            out_hit_r;
  logic                            out_miss_r;
  logic                            out_evict_r;
  logic                            out_mod_r;

  // Address split
  logic [SHAMT_W-1:0]              sbits_x;
  logic [SHAMT_W-1:0]              sbits_eff;
  logic [ADDR_WIDTH-1:0]           shifted;
  logic [SET_W-1:0]                set_mask;
  logic [SET_W-1:0]                set_calc;
  logic [ADDR_WIDTH-1:0]           tag_calc;

  always_comb begin
    sbits_x   = SHAMT_W'(cfg.set_bits);
    sbits_eff = (sbits_x > SHAMT_W'(MAX_SET_BITS)) ? SHAMT_W'(MAX_SET_BITS) : sbits_x;
    shifted   = addr_r >> cfg.offset_bits;
    set_mask  = ~({SET_W{1'b1}} << sbits_eff);
    set_calc  = shifted[SET_W-1:0] & set_mask;
    tag_calc  = addr_r >> (SHAMT_W'(cfg.offset_bits) + sbits_eff);
  end

  // Effective associativity: 0 acts as 1, clamp at MAX_WAYS
  logic [WX_W-1:0]  ways_x;
  logic [WX_W-1:0]  ways_eff_x;
  logic [CNT_W-1:0] ways_eff;
  logic [WAY_W-1:0] last_way;

  always_comb begin
    ways_x = WX_W'(cfg.ways);
    if (ways_x == '0) begin
      ways_eff_x = WX_W'(1);
    end else if (ways_x > WX_W'(MAX_WAYS)) begin
      ways_eff_x = WX_W'(MAX_WAYS);
    end else begin
      ways_eff_x = ways_x;
    end
    ways_eff = CNT_W'(ways_eff_x);
    last_way = WAY_W'(ways_eff - CNT_W'(1));
  end

  // Current way under scan
  logic              cur_valid;
  logic [RANK_W-1:0] cur_rank;
  logic              tag_match;

  assign cur_valid = valid_rd_r[scan_way_r];
  assign cur_rank  = rank_rd_r[scan_way_r];
  assign tag_match = (tag_rd_r == tag_r);

  // Update decision
  logic                            fill;
  logic                            miss;
  logic                            evict;
  logic                            mod;
  logic [WAY_W-1:0]                hot;
  logic [CNT_W-1:0]                old_rank;
  logic [MAX_WAYS-1:0]             valid_new;
  logic [MAX_WAYS-1:0][RANK_W-1:0] rank_new;

  always_comb begin
    fill  = (nvalid_r < ways_eff);
    miss  = !hit_r;
    evict = miss && !fill;
    mod   = (op_r == salc_pkg::OP_MODIFY);
    if (hit_r) begin
      hot      = hit_way_r;
      old_rank = CNT_W'(rank_rd_r[hit_way_r]);
    end else if (fill) begin
      hot      = free_way_r;
      old_rank = nvalid_r;
    end else begin
      hot      = best_way_r;
      old_rank = CNT_W'(best_rank_r);
    end
    valid_new = valid_rd_r;
    rank_new  = rank_rd_r;
    // age the valid lines that were younger than the touched one
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (CNT_W'(w) < ways_eff && WAY_W'(w) != hot && valid_rd_r[w] &&
          CNT_W'(rank_rd_r[w]) < old_rank) begin
        rank_new[w] = rank_rd_r[w] + RANK_W'(1);
      end
    end
    rank_new[hot]  = '0;
    valid_new[hot] = 1'b1;
  end

  // Tag read address: way 0 on fetch, then one ahead of the scan
  logic [WAY_W-1:0] rd_way;
  assign rd_way = cmd.fetch ? '0 : scan_way_r + WAY_W'(1);

  always_ff @(posedge clk) begin
    tag_rd_r <= tag_mem[{set_r, rd_way}];
    if (cmd.commit && miss) begin
      tag_mem[{set_r, hot}] <= tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      valid_rd_r <= valid_mem[set_r];
      rank_rd_r  <= rank_mem[set_r];
    end
    if (cmd.clear) begin
      valid_mem[clr_cnt_r] <= '0;
      rank_mem[clr_cnt_r]  <= '0;
    end else if (cmd.commit) begin
      valid_mem[set_r] <= valid_new;
      rank_mem[set_r]  <= rank_new;
    end
  end

  // Item and scan registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      addr_r <= in_address;
    end
    if (cmd.decode) begin
      set_r <= set_calc;
      tag_r <= tag_calc;
    end
    if (cmd.fetch) begin
      scan_way_r   <= '0;
      hit_r        <= 1'b0;
      hit_way_r    <= '0;
      nvalid_r     <= '0;
      free_found_r <= 1'b0;
      free_way_r   <= '0;
      best_way_r   <= '0;
      best_rank_r  <= '0;
    end else if (cmd.scan) begin
      scan_way_r <= scan_way_r + WAY_W'(1);
      if (cur_valid) begin
        nvalid_r <= nvalid_r + CNT_W'(1);
        if (!hit_r && tag_match) begin
          hit_r     <= 1'b1;
          hit_way_r <= scan_way_r;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_way_r   <= scan_way_r;
      end
      // oldest line, lowest way on a tie
      if (scan_way_r == '0 || cur_rank > best_rank_r) begin
        best_way_r  <= scan_way_r;
        best_rank_r <= cur_rank;
      end
    end
  end

  // Control state: clear sweep, totals, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      evicts_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + SET_W'(1);
      end
      if (cmd.commit) begin
        hits_r      <= hits_r + TW'(hit_r) + TW'(mod);
        misses_r    <= misses_r + TW'(miss);
        evicts_r    <= evicts_r + TW'(evict);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r   <= hit_r;
      out_miss_r  <= miss;
      out_evict_r <= evict;
      out_mod_r   <= mod;
    end
  end

  assign sts.clear_done = (clr_cnt_r == SET_W'(NUM_SETS - 1));
  assign sts.scan_last  = (scan_way_r == last_way);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_was_hit        = out_hit_r;
  assign out_was_miss       = out_miss_r;
  assign out_was_eviction   = out_evict_r;
  assign out_modify_hit     = out_mod_r;
  assign out_hit_total      = hits_r;
  assign out_miss_total     = misses_r;
  assign out_eviction_total = evicts_r;

  `SALC_ASSERT(a_hit_xor_miss, out_valid_r |-> (out_hit_r != out_miss_r),
    "result must be exactly one of hit or miss")
  `SALC_ASSERT(a_evict_is_miss, (out_valid_r && out_evict_r) |-> out_miss_r,
    "eviction reported without a miss")

endmodule

>>> rtl/set_assoc_lru_cache_sim.sv
// Channel   Handshake                          Payload
// in        in_valid / in_ready                in_operation, in_address
// out       out_valid / out_ready              out_was_hit .. out_eviction_total
// cfg       cfg_psel, cfg_penable, cfg_pready  cfg_pwrite, cfg_paddr, cfg_pwdata, cfg_prdata
//
// An item passes through accept, address split, row fetch, one tag compare per
// way and update, ways being ways_in_use clamped to 1..MAX_WAYS; the tag memory
// is read one way at a time, which is why the compares step way by way.
// After reset a clearing pass wipes the valid bits and ranks of every set;
// in_ready stays low until it is done.
// A finished result sits in the output register; the next item is accepted
// meanwhile, and it waits at the update step only if that register is full and not being read.
module set_assoc_lru_cache_sim #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_operation,
  input  logic [ADDR_WIDTH-1:0]            in_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_was_hit,
  output logic                             out_was_miss,
  output logic                             out_was_eviction,
  output logic                             out_modify_hit,
  output logic [salc_pkg::TOTAL_W-1:0]     out_hit_total,
  output logic [salc_pkg::TOTAL_W-1:0]     out_miss_total,
  output logic [salc_pkg::TOTAL_W-1:0]     out_eviction_total,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [salc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [salc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  salc_pkg::cfg_t    cfg;
  salc_pkg::dp_cmd_t cmd;
  salc_pkg::dp_sts_t sts;

  salc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  salc_dp #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_address         (in_address),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_was_hit        (out_was_hit),
    .out_was_miss       (out_was_miss),
    .out_was_eviction   (out_was_eviction),
    .out_modify_hit     (out_modify_hit),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total),
    .out_eviction_total (out_eviction_total)
  );

endmodule
